>>> design/block_fault_injector_stats_assert.svh
// Assertion macros shared by the fault injector and statistics RTL.
`ifndef BLOCK_FAULT_INJECTOR_STATS_ASSERT_SVH
`define BLOCK_FAULT_INJECTOR_STATS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BFIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bfis check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define BFIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bfis check failed");

`endif

>>> design/bfis_pkg.sv
// Package for the block fault injector: types, codes and counter helpers.
`default_nettype none
package bfis_pkg;

    localparam int SECTOR_ADDR_WIDTH = 32;
    localparam int COUNTER_WIDTH     = 64;
    localparam int NUM_STATS         = 12;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [31:0] SECTOR_MASK = (SECTOR_ADDR_WIDTH >= 32) ? ALL_ONES32 :
        32'((64'd1 << SECTOR_ADDR_WIDTH) - 64'd1);
    localparam logic [63:0] CNT_TOP64 = (COUNTER_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
        ((64'd1 << COUNTER_WIDTH) - 64'd1);

    // Request modes
    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_FLUSH  = 3'd2,
        MODE_RD_CNT = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_OP_MASK   = 3'd0,
        CFG_WIN_START = 3'd1,
        CFG_WIN_LEN   = 3'd2,
        CFG_PASS_BUDG = 3'd3,
        CFG_FAIL_BUDG = 3'd4,
        CFG_ERR_VALUE = 3'd5,
        CFG_SEC_LOG2  = 3'd6
    } t_cfg_idx;

    // Statistic indexes
    localparam logic [3:0] STAT_CALL_RD   = 4'd0;
    localparam logic [3:0] STAT_FAIL_RD   = 4'd3;
    localparam logic [3:0] STAT_MATCH     = 4'd6;
    localparam logic [3:0] STAT_INJECT    = 4'd7;
    localparam logic [3:0] STAT_SEC_RD    = 4'd8;
    localparam logic [3:0] STAT_SEC_WR    = 4'd9;
    localparam logic [3:0] STAT_BYTES_RD  = 4'd10;
    localparam logic [3:0] STAT_BYTES_WR  = 4'd11;

    typedef logic [COUNTER_WIDTH-1:0] t_count;

    // One item's worth of statistic updates
    typedef struct packed {
        logic        valid;
        logic        clear;
        logic [2:0]  call_op;   // one-hot per operation
        logic [2:0]  fail_op;   // one-hot per operation
        logic        match;
        logic        inject;
        logic [1:0]  xfer_op;   // bit0 read, bit1 write: sectors and bytes counted
        logic [31:0] sectors;
        logic [63:0] bytes;
    } t_stat_upd;

    // Saturating add of a 64-bit amount into a counter
    function automatic t_count sat_add(input t_count cur, input logic [63:0] amt);
        logic [COUNTER_WIDTH:0] sum;
        t_count                 a;
        a   = (amt > CNT_TOP64) ? '1 : amt[COUNTER_WIDTH-1:0];
        sum = {1'b0, cur} + {1'b0, a};
        return sum[COUNTER_WIDTH] ? '1 : sum[COUNTER_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/block_fault_injector_stats.sv
// An accepted request item passes through the input register to the result register.
// One request item per cycle while the result stream is not stalled; the budget and
// counter updates for an item are made as it leaves the input register.
// Reset (synchronous, active low) clears all counters and budgets and loads the
// configuration defaults (error code 1, sector size log2 9, rest zero).
`default_nettype none
module block_fault_injector_stats (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [71:0] i_s_tdata,  // start_lba[31:0], sector_total[63:32],
                                    // counter_index[67:64], zero fill
    input  wire  [2:0]  i_s_tuser,  // mode[2:0]
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [71:0] o_m_tdata,  // error_value[7:0], counter_value[71:8]
    output logic        o_m_tuser,  // failed[0]
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    // Input register
    logic        r_in_valid;
    logic [2:0]  r_mode;
    logic [31:0] r_first;
    logic [31:0] r_total;
    logic [3:0]  r_cidx;

    // Configuration
    logic [2:0]  r_op_mask;
    logic [31:0] r_win_start;
    logic [31:0] r_win_len;
    logic [7:0]  r_err_val;
    logic [4:0]  r_sec_log2;
    logic [31:0] r_pass_rem, n_pass_rem;
    logic [31:0] r_fail_rem, n_fail_rem;

    // Output register
    logic        r_out_valid;
    logic        r_failed, n_failed;
    logic [7:0]  r_err, n_err;
    logic [63:0] r_cnt, n_cnt;

    logic        advance;
    logic        process;
    logic        cfg_wr;
    logic [63:0] rd_data;
    bfis_pkg::t_stat_upd upd;

    assign advance     = !r_out_valid || i_m_tready;
    assign process     = r_in_valid && advance;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Capture request items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_mode  <= i_s_tuser;
            r_first <= i_s_tdata[31:0];
            r_total <= i_s_tdata[63:32];
            r_cidx  <= i_s_tdata[67:64];
        end
    end

    // Match, budgets and statistics update for the registered item
    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic        in_win;
        logic        is_op;
        logic        match;
        logic        fail;
        logic [1:0]  op;
        logic [2:0]  op_hot;

        a      = r_first & bfis_pkg::SECTOR_MASK;
        b      = r_win_start & bfis_pkg::SECTOR_MASK;
        in_win = ({1'b0, a} < ({1'b0, b} + {1'b0, r_win_len})) &&
                 ({1'b0, b} < ({1'b0, a} + {1'b0, r_total}));
        is_op  = (r_mode == bfis_pkg::MODE_READ) || (r_mode == bfis_pkg::MODE_WRITE) ||
                 (r_mode == bfis_pkg::MODE_FLUSH);
        op     = r_mode[1:0];
        op_hot = is_op ? (3'b001 << op) : 3'b000;
        match  = is_op && ((r_op_mask & op_hot) != 3'b000) &&
                 ((r_mode == bfis_pkg::MODE_FLUSH) || (r_win_len == 32'd0) || in_win);

        n_pass_rem = r_pass_rem;
        n_fail_rem = r_fail_rem;
        fail       = 1'b0;
        if (match) begin
            if (r_pass_rem != 32'd0) begin
                n_pass_rem = r_pass_rem - 32'd1;
            end else if (r_fail_rem != 32'd0) begin
                if (r_fail_rem != bfis_pkg::ALL_ONES32) n_fail_rem = r_fail_rem - 32'd1;
                fail = 1'b1;
            end
        end

        upd.valid   = process;
        upd.clear   = (r_mode == bfis_pkg::MODE_CLEAR);
        upd.call_op = op_hot;
        upd.fail_op = fail ? op_hot : 3'b000;
        upd.match   = match;
        upd.inject  = fail;
        upd.xfer_op = (fail || !is_op) ? 2'b00 : op_hot[1:0];
        upd.sectors = r_total;
        upd.bytes   = {32'd0, r_total} << r_sec_log2;

        n_failed = fail;
        n_err    = fail ? r_err_val : 8'd0;
        n_cnt    = (r_mode == bfis_pkg::MODE_RD_CNT) ? rd_data : 64'd0;
    end

    // Configuration registers and running budgets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mask   <= 3'd0;
            r_win_start <= 32'd0;
            r_win_len   <= 32'd0;
            r_err_val   <= 8'd1;
            r_sec_log2  <= 5'd9;
            r_pass_rem  <= 32'd0;
            r_fail_rem  <= 32'd0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                bfis_pkg::CFG_OP_MASK:   r_op_mask   <= i_cfg_data[2:0];
                bfis_pkg::CFG_WIN_START: r_win_start <= i_cfg_data;
                bfis_pkg::CFG_WIN_LEN:   r_win_len   <= i_cfg_data;
                bfis_pkg::CFG_PASS_BUDG: r_pass_rem  <= i_cfg_data;
                bfis_pkg::CFG_FAIL_BUDG: r_fail_rem  <= i_cfg_data;
                bfis_pkg::CFG_ERR_VALUE: r_err_val   <= i_cfg_data[7:0];
                bfis_pkg::CFG_SEC_LOG2:  r_sec_log2  <= i_cfg_data[4:0];
                default: ;
            endcase
        end else if (process) begin
            r_pass_rem <= n_pass_rem;
            r_fail_rem <= n_fail_rem;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (process) begin
            r_failed <= n_failed;
            r_err    <= n_err;
            r_cnt    <= n_cnt;
        end
    end

    bfis_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (upd),
        .i_rd_index (r_cidx),
        .o_rd_data  (rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_failed;
    assign o_m_tdata  = {r_cnt, r_err};

`include "block_fault_injector_stats_assert.svh"

    // a passed request carries no error code
    `BFIS_ASSERT_NOW(a_pass_no_err, r_out_valid && !r_failed, r_err == 8'd0)
    // a failed request never carries a counter value
    `BFIS_ASSERT_NOW(a_fail_no_cnt, r_out_valid && r_failed, r_cnt == 64'd0)
    // a processed item always shows up in the result register
    `BFIS_ASSERT_NEXT(a_proc_out, process, r_out_valid)
    // unlimited fail budget stays unlimited without a config write
    `BFIS_ASSERT_NEXT(a_fail_forever, (r_fail_rem == bfis_pkg::ALL_ONES32) && !cfg_wr,
        r_fail_rem == bfis_pkg::ALL_ONES32)
    // pass budget only counts down between config writes
    `BFIS_ASSERT_NEXT(a_pass_down, !cfg_wr, r_pass_rem <= $past(r_pass_rem))

endmodule
`default_nettype wire

>>> design/bfis_stats.sv
// Statistics bank: twelve saturating counters with one read port and bulk clear.
`default_nettype none
module bfis_stats (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  bfis_pkg::t_stat_upd  i_upd,
    input  wire  [3:0]                 i_rd_index,
    output logic [63:0]                o_rd_data
);

    bfis_pkg::t_count r_stat [bfis_pkg::NUM_STATS];
    bfis_pkg::t_count n_stat [bfis_pkg::NUM_STATS];

    // Per-counter increment amount and saturating next value
    always_comb begin
        logic [63:0] amt;
        for (int i = 0; i < bfis_pkg::NUM_STATS; i++) begin
            amt = 64'd0;
            if (4'(i) < bfis_pkg::STAT_FAIL_RD) begin
                amt = {63'd0, i_upd.call_op[i]};
            end else if (4'(i) < bfis_pkg::STAT_MATCH) begin
                amt = {63'd0, i_upd.fail_op[i - 3]};
            end else if (4'(i) == bfis_pkg::STAT_MATCH) begin
                amt = {63'd0, i_upd.match};
            end else if (4'(i) == bfis_pkg::STAT_INJECT) begin
                amt = {63'd0, i_upd.inject};
            end else if (4'(i) == bfis_pkg::STAT_SEC_RD) begin
                amt = i_upd.xfer_op[0] ? {32'd0, i_upd.sectors} : 64'd0;
            end else if (4'(i) == bfis_pkg::STAT_SEC_WR) begin
                amt = i_upd.xfer_op[1] ? {32'd0, i_upd.sectors} : 64'd0;
            end else if (4'(i) == bfis_pkg::STAT_BYTES_RD) begin
                amt = i_upd.xfer_op[0] ? i_upd.bytes : 64'd0;
            end else begin
                amt = i_upd.xfer_op[1] ? i_upd.bytes : 64'd0;
            end
            n_stat[i] = bfis_pkg::sat_add(r_stat[i], amt);
        end
    end

    // Counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfis_pkg::NUM_STATS; i++) r_stat[i] <= '0;
        end else if (i_upd.valid) begin
            for (int i = 0; i < bfis_pkg::NUM_STATS; i++) begin
                r_stat[i] <= i_upd.clear ? '0 : n_stat[i];
            end
        end
    end

    // Read port; indexes past the last counter read as zero
    always_comb begin
        o_rd_data = 64'd0;
        if (i_rd_index <= bfis_pkg::STAT_BYTES_WR) begin
            o_rd_data = 64'(r_stat[i_rd_index]);
        end
    end

endmodule
`default_nettype wire
